/* design/tldr_pkg.sv */
// Package for the timed-leg dead reckoning core.
// Holds payload structs, leg entry type, opcodes, FSM states, constant-divider
// and CORDIC constants. No dependencies.
package tldr_pkg;

  localparam int MAX_LEGS_DEF        = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 16;

  localparam int CORDIC_STEPS = 30;
  localparam logic [33:0] CORDIC_GAIN = 34'd652032874;

  // reciprocal multiplication: floor(n / d) = (n * RCP) >> SH over the used range
  localparam int DIV_MW = 29;
  localparam int DIV_QW = 24;
  localparam logic [DIV_MW-1:0] RCP_225 = 29'd9544372;
  localparam logic [DIV_MW-1:0] RCP_45  = 29'd46604;
  localparam logic [DIV_MW-1:0] RCP_125 = 29'd274877907;
  localparam int SH_225 = 31;
  localparam int SH_45  = 21;
  localparam int SH_125 = 35;

  // 1852 m per nautical mile; pi/2 in Q30 over 1440 split into whole and remainder
  localparam logic [10:0] KNOT_MM      = 11'd1852;
  localparam logic [20:0] ANG_STEP_INT = 21'd1171270;
  localparam logic [10:0] ANG_STEP_REM = 11'd1826;

  localparam logic [12:0] FULL_TURN    = 13'd5760;
  localparam logic [12:0] QUARTER_TURN = 13'd1440;

  typedef enum logic [1:0] {
    OP_WRITE_LEG = 2'd0,
    OP_PLACE     = 2'd1,
    OP_STEP      = 2'd2,
    OP_NOP       = 2'd3
  } tldr_op_e;

  typedef enum logic [1:0] {
    DIV_SPEED,
    DIV_ANGLE,
    DIV_MOVE
  } tldr_div_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_SPD_GO,
    ST_SPD_W,
    ST_ANG_GO,
    ST_ANG_W,
    ST_COR_GO,
    ST_COR_W,
    ST_MUL1,
    ST_MUL2,
    ST_MOV_GO,
    ST_MOV_W,
    ST_DONE
  } tldr_state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         leg_index;
    logic [31:0]        leg_start_ms;
    logic [11:0]        leg_speed_knots;
    logic [12:0]        leg_bearing;
    logic signed [31:0] place_x;
    logic signed [31:0] place_z;
    logic [15:0]        delta_ms;
    logic [31:0]        scenario_ms;
  } tldr_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic [12:0]        heading_out;
    logic [15:0]        speed_out;
    logic [3:0]         leg_used;
  } tldr_out_t;

  typedef struct packed {
    logic [31:0] start_ms;
    logic [11:0] speed;
    logic [12:0] bearing;
  } tldr_leg_t;

  function automatic logic [30:0] tldr_atan(input logic [4:0] i);
    logic [30:0] a;
    unique case (i)
      5'd0:  a = 31'h3243F6A8;
      5'd1:  a = 31'h1DAC6705;
      5'd2:  a = 31'h0FADBAFC;
      5'd3:  a = 31'h07F56EA6;
      5'd4:  a = 31'h03FEAB76;
      5'd5:  a = 31'h01FFD55B;
      5'd6:  a = 31'h00FFFAAA;
      5'd7:  a = 31'h007FFF55;
      5'd8:  a = 31'h003FFFEA;
      5'd9:  a = 31'h001FFFFD;
      5'd10: a = 31'h000FFFFF;
      5'd11: a = 31'h0007FFFF;
      5'd12: a = 31'h0003FFFF;
      5'd13: a = 31'h0001FFFF;
      5'd14: a = 31'h0000FFFF;
      5'd15: a = 31'h00007FFF;
      5'd16: a = 31'h00003FFF;
      5'd17: a = 31'h00001FFF;
      5'd18: a = 31'h00000FFF;
      5'd19: a = 31'h000007FF;
      5'd20: a = 31'h000003FF;
      5'd21: a = 31'h000001FF;
      5'd22: a = 31'h000000FF;
      5'd23: a = 31'h0000007F;
      5'd24: a = 31'h0000003F;
      5'd25: a = 31'h0000001F;
      5'd26: a = 31'h0000000F;
      5'd27: a = 31'h00000007;
      5'd28: a = 31'h00000003;
      5'd29: a = 31'h00000001;
      default: a = 31'h0;
    endcase
    return a;
  endfunction

endpackage

/* design/tldr_leg_mem.sv */
// Leg table: synchronous single-write, single-read memory with registered read data.
// Depends on tldr_pkg for the entry type.
module tldr_leg_mem import tldr_pkg::*; #(
  parameter int DEPTH = MAX_LEGS_DEF,
  parameter int AW    = 4
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  tldr_leg_t       wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output tldr_leg_t       rdata_o
);

  tldr_leg_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* design/tldr_div.sv */
// Division by a small constant through reciprocal multiplication, with registered operands and a registered product.
// Depends on tldr_pkg for widths, reciprocals and shifts.
module tldr_div import tldr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  tldr_div_e         sel_i,
  input  logic [DIV_MW-1:0] dividend_i,
  output logic              done_o,
  output logic [DIV_QW-1:0] quot_o
);

  logic [DIV_MW-1:0]   num_q;
  tldr_div_e           sel_q;
  logic [2*DIV_MW-1:0] prod_q;
  logic                busy_q, done_q;
  logic [DIV_MW-1:0]   rcp;

  always_comb begin
    unique case (sel_q)
      DIV_SPEED: rcp = RCP_225;
      DIV_ANGLE: rcp = RCP_45;
      default:   rcp = RCP_125;
    endcase
  end

  always_comb begin
    unique case (sel_q)
      DIV_SPEED: quot_o = DIV_QW'(prod_q >> SH_225);
      DIV_ANGLE: quot_o = DIV_QW'(prod_q >> SH_45);
      default:   quot_o = DIV_QW'(prod_q >> SH_125);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      sel_q <= sel_i;
    end
    if (busy_q) begin
      prod_q <= (2*DIV_MW)'(num_q) * (2*DIV_MW)'(rcp);
    end
  end

  assign done_o = done_q;

endmodule

/* design/tldr_cordic.sv */
// Iterative rotation-mode CORDIC in Q30, one step per cycle, with output
// rounding and quadrant mapping. Depends on tldr_pkg for the arctangent table.
module tldr_cordic import tldr_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [32:0]                       z0_i,
  input  logic [1:0]                        quad_i,
  output logic                              done_o,
  output logic signed [ANGLE_FRAC_BITS+1:0] sin_o,
  output logic signed [ANGLE_FRAC_BITS+1:0] cos_o
);

  localparam int TW = ANGLE_FRAC_BITS + 2;

  logic signed [33:0] x_q, y_q, z_q;
  logic [4:0]         i_q;
  logic [1:0]         quad_q;
  logic               run_q, fin_q, done_q;
  logic signed [33:0] dx, dy, at;
  logic signed [TW-1:0] s_f, c_f;

  function automatic logic signed [TW-1:0] to_frac(input logic signed [33:0] v);
    logic signed [33:0] r;
    logic signed [33:0] one;
    r   = (v + (34'sd1 <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
    one = 34'sd1 <<< ANGLE_FRAC_BITS;
    if (r > one) r = one;
    if (r < -one) r = -one;
    return TW'(r);
  endfunction

  assign dx  = y_q >>> i_q;
  assign dy  = x_q >>> i_q;
  assign at  = $signed({3'b000, tldr_atan(i_q)});
  assign s_f = to_frac(y_q);
  assign c_f = to_frac(x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        i_q   <= '0;
      end else if (run_q) begin
        i_q <= i_q + 1'b1;
        if (i_q == 5'(CORDIC_STEPS - 1)) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= $signed(CORDIC_GAIN);
      y_q    <= '0;
      z_q    <= $signed({1'b0, z0_i});
      quad_q <= quad_i;
    end else if (run_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
    if (fin_q) begin
      unique case (quad_q)
        2'd0: begin sin_o <= s_f;  cos_o <= c_f;  end
        2'd1: begin sin_o <= c_f;  cos_o <= -s_f; end
        2'd2: begin sin_o <= -s_f; cos_o <= -c_f; end
        default: begin sin_o <= -c_f; cos_o <= s_f; end
      endcase
    end
  end

  assign done_o = done_q;

endmodule

/* design/timed_leg_dead_reckoning_core.sv */
// Timed-leg dead reckoning core: top level with control FSM and position state.
// Depends on tldr_pkg, tldr_leg_mem, tldr_div and tldr_cordic.
//
// Every accepted item gives one result. Leg writes, placement, no-op and a
// time step with an empty table go from idle through ST_DONE to the output
// register. A time step reads and checks one leg per search step and uses
// the 30-step CORDIC, four constant divisions (speed conversion, angle scaling
// and each of the two position updates) through reciprocal multiplication,
// the multiply states ST_MUL1 and ST_MUL2 per axis and the output state. The
// leg table is a synchronous memory read one entry per search step. A finished
// result sits in the output register while the next item is accepted.
module timed_leg_dead_reckoning_core import tldr_pkg::*; #(
  parameter int MAX_LEGS        = MAX_LEGS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tldr_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tldr_out_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [4:0] cfg_data_i
);

  localparam int AW  = (MAX_LEGS > 1) ? $clog2(MAX_LEGS) : 1;
  localparam int CW  = 9;
  localparam int F   = ANGLE_FRAC_BITS;
  localparam int TW  = F + 2;
  localparam int P1W = F + 17;
  localparam int P2W = F + 33;

  tldr_state_e state_q, state_d;

  logic [4:0]         leg_count_q;
  tldr_in_t           item_q;
  logic signed [31:0] x_q, z_q;
  logic [12:0]        heading_q;
  logic [15:0]        speed_q;
  logic [3:0]         leg_q;
  logic [CW-1:0]      k_q;
  tldr_leg_t          prev_q, sel_q;
  logic [1:0]         quad_q;
  logic               axis_q, neg_q;
  logic [P1W-1:0]     p1_q;
  logic [P2W-1:0]     p2_q;
  logic               out_valid_q;
  tldr_out_t          out_q;

  // memory
  logic      mem_we;
  logic [8:0] widx;
  tldr_leg_t mem_wdata, mem_rdata;

  // units
  logic              div_start, div_done;
  tldr_div_e         div_sel;
  logic [DIV_MW-1:0] div_num;
  logic [DIV_QW-1:0] div_quot;
  logic              cor_start, cor_done;
  logic [32:0]       cor_z0;
  logic signed [TW-1:0] sin_v, cos_v;

  logic          accept;
  logic [CW-1:0] cnt;
  logic          cnt_zero, last, hit, out_free;
  logic [CW-1:0] k_m1;
  logic [22:0]   spd_num;
  logic [12:0]   b_mod, rem_b;
  logic [1:0]    quad;
  logic [21:0]   ang_m;
  logic [DIV_MW-1:0] mov_num;
  logic [P2W:0]  mov_sum;
  logic signed [TW-1:0] trig;
  logic [TW-1:0] trig_abs;
  logic signed [34:0] pos_ext, upd;
  logic signed [31:0] upd_sat;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign cnt = ({4'b0, leg_count_q} > CW'(MAX_LEGS)) ? CW'(MAX_LEGS) : {4'b0, leg_count_q};
  assign cnt_zero = (cnt == '0);
  assign last = (k_q == cnt - 1'b1);
  assign hit  = (k_q != '0) && (prev_q.start_ms <= item_q.scenario_ms)
                && (mem_rdata.start_ms > item_q.scenario_ms);
  assign k_m1 = k_q - 1'b1;

  assign widx      = {5'b0, in_data_i.leg_index};
  assign mem_we    = accept && (in_data_i.opcode == OP_WRITE_LEG) && (widx < 9'(MAX_LEGS));
  assign mem_wdata = '{start_ms: in_data_i.leg_start_ms, speed: in_data_i.leg_speed_knots,
                       bearing: in_data_i.leg_bearing};

  tldr_leg_mem #(.DEPTH(MAX_LEGS), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (widx[AW-1:0]),
    .wdata_i (mem_wdata),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // speed: (knots16 * 1852 * 16 + 1800) / 3600 == (knots16 * 1852 + 112) / 225
  assign spd_num = 23'(sel_q.speed) * 23'(KNOT_MM) + 23'd112;

  // angle reduction
  assign b_mod = (heading_q >= FULL_TURN) ? heading_q - FULL_TURN : heading_q;
  always_comb begin
    if (b_mod >= 13'(3 * QUARTER_TURN)) begin
      quad = 2'd3;
    end else if (b_mod >= 13'(2 * QUARTER_TURN)) begin
      quad = 2'd2;
    end else if (b_mod >= QUARTER_TURN) begin
      quad = 2'd1;
    end else begin
      quad = 2'd0;
    end
  end
  assign rem_b  = b_mod - 13'(quad) * QUARTER_TURN;
  // rounded fractional part of rem * pi/2 / 1440, divided by 2880 as >> 6 then / 45
  assign ang_m  = 22'(rem_b) * 22'(ANG_STEP_REM) + 22'd1440;
  assign cor_z0 = 33'(rem_b) * 33'(ANG_STEP_INT) + 33'(div_quot);

  // motion
  assign trig     = axis_q ? cos_v : sin_v;
  assign trig_abs = trig[TW-1] ? TW'(-trig) : TW'(trig);
  assign mov_sum  = (P2W+1)'(p2_q) + ((P2W+1)'(500) << F);
  // divide by 1000 as >> 3 then / 125
  assign mov_num  = mov_sum[F+31:F+3];
  assign pos_ext  = axis_q ? 35'(z_q) : 35'(x_q);
  assign upd      = neg_q ? pos_ext - $signed({11'b0, div_quot})
                          : pos_ext + $signed({11'b0, div_quot});
  assign upd_sat  = (upd > 35'sd2147483647) ? 32'sh7FFFFFFF :
                    (upd < -35'sd2147483648) ? 32'sh80000000 : upd[31:0];

  always_comb begin
    unique case (state_q)
      ST_SPD_GO: begin div_num = DIV_MW'(spd_num);     div_sel = DIV_SPEED; end
      ST_ANG_GO: begin div_num = DIV_MW'(ang_m[21:6]); div_sel = DIV_ANGLE; end
      default:   begin div_num = mov_num;              div_sel = DIV_MOVE;  end
    endcase
  end

  tldr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .sel_i      (div_sel),
    .dividend_i (div_num),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  tldr_cordic #(.ANGLE_FRAC_BITS(F)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .z0_i    (cor_z0),
    .quad_i  (quad_q),
    .done_o  (cor_done),
    .sin_o   (sin_v),
    .cos_o   (cos_v)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.opcode == OP_STEP && !cnt_zero) begin
            state_d = ST_RD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_RD:     state_d = ST_CHK;
      ST_CHK:    state_d = (hit || last) ? ST_SPD_GO : ST_RD;
      ST_SPD_GO: state_d = ST_SPD_W;
      ST_SPD_W:  if (div_done) state_d = ST_ANG_GO;
      ST_ANG_GO: state_d = ST_ANG_W;
      ST_ANG_W:  if (div_done) state_d = ST_COR_GO;
      ST_COR_GO: state_d = ST_COR_W;
      ST_COR_W:  if (cor_done) state_d = ST_MUL1;
      ST_MUL1:   state_d = ST_MUL2;
      ST_MUL2:   state_d = ST_MOV_GO;
      ST_MOV_GO: state_d = ST_MOV_W;
      ST_MOV_W:  if (div_done) state_d = axis_q ? ST_DONE : ST_MUL1;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    cor_start  = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SPD_GO: div_start  = 1'b1;
      ST_ANG_GO: div_start  = 1'b1;
      ST_MOV_GO: div_start  = 1'b1;
      ST_COR_GO: cor_start  = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      leg_count_q <= '0;
      x_q         <= '0;
      z_q         <= '0;
      heading_q   <= '0;
      speed_q     <= '0;
      leg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        leg_count_q <= cfg_data_i;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && in_data_i.opcode == OP_PLACE) begin
            x_q <= in_data_i.place_x;
            z_q <= in_data_i.place_z;
          end
          if (accept && in_data_i.opcode == OP_STEP && cnt_zero) begin
            heading_q <= '0;
            speed_q   <= '0;
            leg_q     <= '0;
          end
        end
        ST_CHK: begin
          if (hit) begin
            heading_q <= prev_q.bearing;
            leg_q     <= k_m1[3:0];
          end else if (last) begin
            heading_q <= mem_rdata.bearing;
            leg_q     <= k_q[3:0];
          end
        end
        ST_SPD_W: if (div_done) speed_q <= div_quot[15:0];
        ST_MOV_W: begin
          if (div_done) begin
            if (axis_q) z_q <= upd_sat;
            else        x_q <= upd_sat;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
      k_q    <= '0;
      axis_q <= 1'b0;
    end
    if (state_q == ST_CHK) begin
      if (hit) begin
        sel_q <= prev_q;
      end else if (last) begin
        sel_q <= mem_rdata;
      end else begin
        prev_q <= mem_rdata;
        k_q    <= k_q + 1'b1;
      end
    end
    if (state_q == ST_ANG_GO) begin
      quad_q <= quad;
    end
    if (state_q == ST_MUL1) begin
      neg_q <= trig[TW-1];
      p1_q  <= P1W'(trig_abs) * P1W'(speed_q);
    end
    if (state_q == ST_MUL2) begin
      p2_q <= P2W'(p1_q) * P2W'(item_q.delta_ms);
    end
    if (state_q == ST_MOV_W && div_done) begin
      axis_q <= 1'b1;
    end
    if (state_q == ST_DONE && out_free) begin
      out_q <= '{pos_x: x_q, pos_z: z_q, heading_out: heading_q,
                 speed_out: speed_q, leg_used: leg_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
